/* rtl/bsc_pkg.sv */
// shared types and constants for the barometric sensor compensation pipeline
package bsc_pkg;

  localparam int TNUM_W = 27;
  localparam int TDEN_W = 18;
  localparam int PNUM_W = 32;
  localparam int PDEN_W = 17;

  localparam logic [1:0] REG_OVERSAMPLING = 2'd0;
  localparam logic [1:0] REG_CAL_A        = 2'd1;
  localparam logic [1:0] REG_CAL_B        = 2'd2;
  localparam logic [1:0] REG_CAL_C        = 2'd3;

  localparam logic signed [27:0] B6_OFS   = 28'sd4000;
  localparam logic [31:0]        B4_OFS   = 32'd32768;
  localparam logic [15:0]        B7_SCALE = 16'd50000;
  localparam logic [11:0]        P_SQ     = 12'd3038;
  localparam logic signed [15:0] P_LIN    = -16'sd7357;
  localparam logic signed [47:0] P_OFS    = 48'sd3791;
  localparam logic [17:0]        P_MAX    = 18'h3ffff;

  typedef struct packed {
    logic signed [17:0] x1;
    logic [23:0]        up;
    logic               neg;
    logic               fault;
  } bsc_tside_t;

  typedef struct packed {
    logic signed [15:0] t;
    logic               dbl;
    logic               fault;
  } bsc_pside_t;

endpackage

/* rtl/bsc_tdiv.sv */
// pipelined restoring divider for the temperature term, one quotient bit per stage
module bsc_tdiv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bsc_pkg::TNUM_W-1:0]  num,
  input  logic [bsc_pkg::TDEN_W-1:0]  den,
  input  bsc_pkg::bsc_tside_t         side_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bsc_pkg::TNUM_W-1:0]  quo,
  output bsc_pkg::bsc_tside_t         side_out
);
  import bsc_pkg::*;

  localparam int N = TNUM_W;
  localparam int D = TDEN_W;

  logic [D-1:0]  rem [N-1];
  logic [D-1:0]  dv  [N-1];
  logic [N-1:0]  nq  [N];
  bsc_tside_t    sd  [N];
  logic          v   [N];
  logic          en  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [D-1:0] rem_in;
    logic [D-1:0] dv_in;
    logic [N-1:0] nq_in;
    bsc_tside_t   sd_in;
    logic         v_in;
    logic [D:0]   trial;
    logic [D:0]   diffv;
    logic         ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dv_in  = den;
      assign nq_in  = num;
      assign sd_in  = side_in;
      assign v_in   = in_valid;
    end else begin : g_rest
      assign rem_in = rem[k-1];
      assign dv_in  = dv[k-1];
      assign nq_in  = nq[k-1];
      assign sd_in  = sd[k-1];
      assign v_in   = v[k-1];
    end

    assign trial = {rem_in, nq_in[N-1]};
    assign diffv = trial - {1'b0, dv_in};
    assign ge    = trial >= {1'b0, dv_in};

    if (k == N-1) begin : g_last
      assign en[k] = !v[k] || out_ready;
    end else begin : g_mid
      assign en[k] = !v[k] || en[k+1];
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem[k] <= ge ? diffv[D-1:0] : trial[D-1:0];
          dv[k]  <= dv_in;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        nq[k] <= {nq_in[N-2:0], ge};
        sd[k] <= sd_in;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[N-1];
  assign quo       = nq[N-1];
  assign side_out  = sd[N-1];

endmodule

/* rtl/bsc_pdiv.sv */
// pipelined restoring divider for the pressure quotient, one quotient bit per stage
module bsc_pdiv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bsc_pkg::PNUM_W-1:0]  num,
  input  logic [bsc_pkg::PDEN_W-1:0]  den,
  input  bsc_pkg::bsc_pside_t         side_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bsc_pkg::PNUM_W-1:0]  quo,
  output bsc_pkg::bsc_pside_t         side_out
);
  import bsc_pkg::*;

  localparam int N = PNUM_W;
  localparam int D = PDEN_W;

  logic [D-1:0]  rem [N-1];
  logic [D-1:0]  dv  [N-1];
  logic [N-1:0]  nq  [N];
  bsc_pside_t    sd  [N];
  logic          v   [N];
  logic          en  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [D-1:0] rem_in;
    logic [D-1:0] dv_in;
    logic [N-1:0] nq_in;
    bsc_pside_t   sd_in;
    logic         v_in;
    logic [D:0]   trial;
    logic [D:0]   diffv;
    logic         ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dv_in  = den;
      assign nq_in  = num;
      assign sd_in  = side_in;
      assign v_in   = in_valid;
    end else begin : g_rest
      assign rem_in = rem[k-1];
      assign dv_in  = dv[k-1];
      assign nq_in  = nq[k-1];
      assign sd_in  = sd[k-1];
      assign v_in   = v[k-1];
    end

    assign trial = {rem_in, nq_in[N-1]};
    assign diffv = trial - {1'b0, dv_in};
    assign ge    = trial >= {1'b0, dv_in};

    if (k == N-1) begin : g_last
      assign en[k] = !v[k] || out_ready;
    end else begin : g_mid
      assign en[k] = !v[k] || en[k+1];
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem[k] <= ge ? diffv[D-1:0] : trial[D-1:0];
          dv[k]  <= dv_in;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        nq[k] <= {nq_in[N-2:0], ge};
        sd[k] <= sd_in;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[N-1];
  assign quo       = nq[N-1];
  assign side_out  = sd[N-1];

endmodule

/* rtl/barometric_sensor_compensation.sv */
// Compensates one raw temperature and pressure reading per request into tenths of a
// degree and pascals. The pipeline takes a new request every cycle while the output is not
// stalled and passes each through three arithmetic stages, a 27-stage divider for the
// temperature term, six arithmetic stages, a 32-stage divider for the pressure
// quotient and three final stages. A stalled output holds back only as far as the
// first empty stage, so gaps in the pipeline are filled while a result waits.
// Configuration is written through cfg_we/cfg_index/cfg_data and must only change
// while the pipeline is empty. A zero divisor sets divide_fault and zeroes both values.
module barometric_sensor_compensation (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        raw_temperature,
  input  logic [23:0]        raw_pressure,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] temperature_tenths,
  output logic [17:0]        pressure_pascal,
  output logic               divide_fault
);
  import bsc_pkg::*;

  // configuration
  logic [1:0]  oversampling;
  logic [63:0] cal_a;
  logic [63:0] cal_b;
  logic [31:0] cal_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      oversampling <= '0;
      cal_a        <= '0;
      cal_b        <= '0;
      cal_c        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OVERSAMPLING: oversampling <= cfg_data[1:0];
        REG_CAL_A:        cal_a        <= cfg_data;
        REG_CAL_B:        cal_b        <= cfg_data;
        REG_CAL_C:        cal_c        <= cfg_data[31:0];
        default:          ;
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;

  assign ac1 = cal_a[63:48];
  assign ac2 = cal_a[47:32];
  assign ac3 = cal_a[31:16];
  assign ac4 = cal_a[15:0];
  assign ac5 = cal_b[63:48];
  assign ac6 = cal_b[47:32];
  assign b1  = cal_b[31:16];
  assign b2  = cal_b[15:0];
  assign mc  = cal_c[31:16];
  assign md  = cal_c[15:0];

  // stage handshake
  logic v_a, v_b, v_c, v_d, v_e, v_f, v_g, v_h, v_i, v_k, v_l;
  logic en_a, en_b, en_c, en_d, en_e, en_f, en_g, en_h, en_i, en_k, en_l, en_m;
  logic tdiv_ready, tdiv_valid, pdiv_ready, pdiv_valid;

  assign en_m = !out_valid || out_ready;
  assign en_l = !v_l || en_m;
  assign en_k = !v_k || en_l;
  assign en_i = !v_i || pdiv_ready;
  assign en_h = !v_h || en_i;
  assign en_g = !v_g || en_h;
  assign en_f = !v_f || en_g;
  assign en_e = !v_e || en_f;
  assign en_d = !v_d || en_e;
  assign en_c = !v_c || tdiv_ready;
  assign en_b = !v_b || en_c;
  assign en_a = !v_a || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0; v_b <= 1'b0; v_c <= 1'b0; v_d <= 1'b0; v_e <= 1'b0; v_f <= 1'b0;
      v_g <= 1'b0; v_h <= 1'b0; v_i <= 1'b0; v_k <= 1'b0; v_l <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) v_a <= in_valid;
      if (en_b) v_b <= v_a;
      if (en_c) v_c <= v_b;
      if (en_d) v_d <= tdiv_valid;
      if (en_e) v_e <= v_d;
      if (en_f) v_f <= v_e;
      if (en_g) v_g <= v_f;
      if (en_h) v_h <= v_g;
      if (en_i) v_i <= v_h;
      if (en_k) v_k <= pdiv_valid;
      if (en_l) v_l <= v_k;
      if (en_m) out_valid <= v_l;
    end
  end

  // stage a: temperature offset, pressure alignment
  logic signed [16:0] a_diff;
  logic [23:0]        a_up;

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_diff <= $signed({1'b0, raw_temperature}) - $signed({1'b0, ac6});
      a_up   <= raw_pressure >> (4'd8 - {2'b00, oversampling});
    end
  end

  // stage b: x1
  logic signed [33:0] prod_b;
  logic signed [17:0] b_x1;
  logic [23:0]        b_up;

  assign prod_b = a_diff * $signed({1'b0, ac5});

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_x1 <= prod_b[32:15];
      b_up <= a_up;
    end
  end

  // stage c: divider operands as magnitudes
  logic signed [18:0] den_s;
  logic [15:0]        mc_abs;
  logic [TNUM_W-1:0]  c_num;
  logic [TDEN_W-1:0]  c_den;
  bsc_tside_t         c_side;

  assign den_s  = {b_x1[17], b_x1} + {{3{md[15]}}, md};
  assign mc_abs = mc[15] ? 16'(-mc) : mc;

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_num        <= {mc_abs, 11'b0};
      c_den        <= den_s[18] ? TDEN_W'(-den_s) : den_s[TDEN_W-1:0];
      c_side.x1    <= b_x1;
      c_side.up    <= b_up;
      c_side.neg   <= mc[15] ^ den_s[18];
      c_side.fault <= den_s == '0;
    end
  end

  logic [TNUM_W-1:0] tq;
  bsc_tside_t        tq_side;

  bsc_tdiv u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_c),
    .in_ready  (tdiv_ready),
    .num       (c_num),
    .den       (c_den),
    .side_in   (c_side),
    .out_valid (tdiv_valid),
    .out_ready (en_d),
    .quo       (tq),
    .side_out  (tq_side)
  );

  // stage d: b5
  logic signed [27:0] x2_d;
  logic signed [27:0] d_b5;
  logic [23:0]        d_up;
  logic               d_fault;

  assign x2_d = tq_side.neg ? -$signed({1'b0, tq}) : $signed({1'b0, tq});

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_b5    <= {{10{tq_side.x1[17]}}, tq_side.x1} + x2_d;
      d_up    <= tq_side.up;
      d_fault <= tq_side.fault;
    end
  end

  // stage e: temperature, b6
  logic signed [27:0] b5r;
  logic signed [23:0] tt;
  logic signed [15:0] e_t;
  logic signed [27:0] e_b6;
  logic [23:0]        e_up;
  logic               e_fault;

  assign b5r = d_b5 + 28'sd8;
  assign tt  = b5r[27:4];

  always_ff @(posedge clk) begin
    if (en_e) begin
      e_t     <= (tt > 24'sd32767) ? 16'sh7fff :
                 (tt < -24'sd32768) ? 16'sh8000 : tt[15:0];
      e_b6    <= d_b5 - B6_OFS;
      e_up    <= d_up;
      e_fault <= d_fault;
    end
  end

  // stage f: products of b6
  logic signed [55:0] f_sq;
  logic signed [43:0] f_ac2b6, f_ac3b6;
  logic signed [15:0] f_t;
  logic [23:0]        f_up;
  logic               f_fault;

  always_ff @(posedge clk) begin
    if (en_f) begin
      f_sq    <= e_b6 * e_b6;
      f_ac2b6 <= ac2 * e_b6;
      f_ac3b6 <= ac3 * e_b6;
      f_t     <= e_t;
      f_up    <= e_up;
      f_fault <= e_fault;
    end
  end

  // stage g: products of the squared term
  logic signed [42:0] sqs;
  logic signed [58:0] g_b2sq, g_b1sq;
  logic signed [43:0] g_ac2b6, g_ac3b6;
  logic signed [15:0] g_t;
  logic [23:0]        g_up;
  logic               g_fault;

  assign sqs = $signed({1'b0, f_sq[53:12]});

  always_ff @(posedge clk) begin
    if (en_g) begin
      g_b2sq  <= b2 * sqs;
      g_b1sq  <= b1 * sqs;
      g_ac2b6 <= f_ac2b6;
      g_ac3b6 <= f_ac3b6;
      g_t     <= f_t;
      g_up    <= f_up;
      g_fault <= f_fault;
    end
  end

  // stage h: b3 and the b4 operand
  logic signed [55:0] b3_sum, b3_sc, b3_q;
  logic signed [47:0] x3_sum, x3_s;
  logic [31:0]        h_b3, h_x3c;
  logic signed [15:0] h_t;
  logic [23:0]        h_up;
  logic               h_fault;

  assign b3_sum = 56'((g_b2sq >>> 11) + (g_ac2b6 >>> 11) + (ac1 <<< 2));
  assign b3_sc  = (b3_sum <<< oversampling) + 56'sd2;
  assign b3_q   = (b3_sc + (b3_sc[55] ? 56'sd3 : 56'sd0)) >>> 2;
  assign x3_sum = 48'((g_ac3b6 >>> 13) + (g_b1sq >>> 16) + 48'sd2);
  assign x3_s   = x3_sum >>> 2;

  always_ff @(posedge clk) begin
    if (en_h) begin
      h_b3    <= b3_q[31:0];
      h_x3c   <= x3_s[31:0] + B4_OFS;
      h_t     <= g_t;
      h_up    <= g_up;
      h_fault <= g_fault;
    end
  end

  // stage i: b4, b7
  logic [47:0]        prod4, prod7;
  logic [31:0]        diff_i;
  logic [15:0]        scale_i;
  logic [PDEN_W-1:0]  i_b4;
  logic [31:0]        i_b7;
  logic signed [15:0] i_t;
  logic               i_fault;

  assign prod4   = h_x3c * ac4;
  assign diff_i  = {8'b0, h_up} - h_b3;
  assign scale_i = B7_SCALE >> oversampling;
  assign prod7   = diff_i * scale_i;

  always_ff @(posedge clk) begin
    if (en_i) begin
      i_b4    <= prod4[31:15];
      i_b7    <= prod7[31:0];
      i_t     <= h_t;
      i_fault <= h_fault || (prod4[31:15] == '0);
    end
  end

  logic [PNUM_W-1:0] p_num;
  bsc_pside_t        p_side;
  logic [PNUM_W-1:0] pq;
  bsc_pside_t        pq_side;

  assign p_num        = i_b7[31] ? i_b7 : {i_b7[30:0], 1'b0};
  assign p_side.t     = i_t;
  assign p_side.dbl   = i_b7[31];
  assign p_side.fault = i_fault;

  bsc_pdiv u_pdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_i),
    .in_ready  (pdiv_ready),
    .num       (p_num),
    .den       (i_b4),
    .side_in   (p_side),
    .out_valid (pdiv_valid),
    .out_ready (en_k),
    .quo       (pq),
    .side_out  (pq_side)
  );

  // stage k: pressure correction products
  logic [31:0]        q_k;
  logic [31:0]        k_q;
  logic [47:0]        k_sqr;
  logic signed [47:0] k_lin;
  logic signed [15:0] k_t;
  logic               k_fault;

  assign q_k = pq_side.dbl ? {pq[30:0], 1'b0} : pq;

  always_ff @(posedge clk) begin
    if (en_k) begin
      k_q     <= q_k;
      k_sqr   <= q_k[31:8] * q_k[31:8];
      k_lin   <= P_LIN * $signed({1'b0, q_k});
      k_t     <= pq_side.t;
      k_fault <= pq_side.fault;
    end
  end

  // stage l: scaled correction terms
  logic [59:0]        prod_l;
  logic [43:0]        l_x1;
  logic signed [31:0] l_x2;
  logic [31:0]        l_q;
  logic signed [15:0] l_t;
  logic               l_fault;

  assign prod_l = k_sqr * P_SQ;

  always_ff @(posedge clk) begin
    if (en_l) begin
      l_x1    <= prod_l[59:16];
      l_x2    <= k_lin[47:16];
      l_q     <= k_q;
      l_t     <= k_t;
      l_fault <= k_fault;
    end
  end

  // stage m: final pressure, saturation, output register
  logic signed [47:0] msum, mcorr, pm;

  assign msum  = $signed({4'b0, l_x1}) + l_x2 + P_OFS;
  assign mcorr = msum >>> 4;
  assign pm    = $signed({16'b0, l_q}) + mcorr;

  always_ff @(posedge clk) begin
    if (en_m) begin
      divide_fault       <= l_fault;
      temperature_tenths <= l_fault ? 16'sd0 : l_t;
      if (l_fault || pm[47]) begin
        pressure_pascal <= '0;
      end else if (pm > $signed({30'b0, P_MAX})) begin
        pressure_pascal <= P_MAX;
      end else begin
        pressure_pascal <= pm[17:0];
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with an empty output stage");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_fault) |-> (temperature_tenths == 16'sd0 && pressure_pascal == '0))
    else $error("faulted result carries non-zero values");
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");
`endif

endmodule

/* sim/bsc_checker.sv */
// checker for the barometric sensor compensation pipeline: predicts and compares each result
`timescale 1ns / 1ps
module bsc_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [15:0]        raw_temperature,
  input  logic [23:0]        raw_pressure,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] temperature_tenths,
  input  logic [17:0]        pressure_pascal,
  input  logic               divide_fault,
  output int                 fail_count,
  output int                 pending
);
  import bsc_pkg::*;

  typedef struct packed {
    logic signed [15:0] t;
    logic [17:0]        p;
    logic               fault;
  } reading_t;

  logic [1:0]  osr;
  logic [63:0] cal_a, cal_b;
  logic [31:0] cal_c;
  reading_t    readings_due[$];

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic reading_t compensate(logic [15:0] ut_raw, logic [23:0] up_raw);
    reading_t r;
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut;
    longint x1, x2, x3, b3, b5, b6, sq, t, p, den;
    longint unsigned up, b4, b7, q;
    ac1 = longint'($signed(cal_a[63:48])); ac2 = longint'($signed(cal_a[47:32]));
    ac3 = longint'($signed(cal_a[31:16])); ac4 = longint'(cal_a[15:0]);
    ac5 = longint'(cal_b[63:48]); ac6 = longint'(cal_b[47:32]);
    b1 = longint'($signed(cal_b[31:16])); b2 = longint'($signed(cal_b[15:0]));
    mc = longint'($signed(cal_c[31:16])); md = longint'($signed(cal_c[15:0]));
    ut = longint'(ut_raw);
    up = longint'(up_raw) >> (8 - osr);
    r = '0;
    x1 = floor_shr((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) begin
      r.fault = 1'b1;
      return r;
    end
    x2 = (mc * 2048) / den;
    b5 = x1 + x2;
    t = floor_shr(b5 + 8, 4);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    b6 = b5 - B6_OFS;
    sq = floor_shr(b6 * b6, 12);
    x1 = floor_shr(b2 * sq, 11);
    x2 = floor_shr(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = ((ac1 * 4 + x3) * (longint'(1) << osr) + 2) / 4;
    x1 = floor_shr(ac3 * b6, 13);
    x2 = floor_shr(b1 * sq, 16);
    x3 = floor_shr(x1 + x2 + 2, 2);
    b4 = (((longint'(x3 + 32768) & 64'hffffffff) * ac4) & 64'hffffffff) >> 15;
    if (b4 == 0) begin
      r.fault = 1'b1;
      return r;
    end
    b7 = (((up - b3) & 64'hffffffff) * (longint'(B7_SCALE) >> osr)) & 64'hffffffff;
    if (b7 < 64'h80000000) q = (b7 * 2) / b4;
    else q = ((b7 / b4) * 2) & 64'hffffffff;
    p = longint'(q);
    x1 = floor_shr(p, 8) * floor_shr(p, 8);
    x1 = floor_shr(x1 * P_SQ, 16);
    x2 = floor_shr(P_LIN * p, 16);
    p = p + floor_shr(x1 + x2 + P_OFS, 4);
    if (p < 0) p = 0;
    if (p > 262143) p = 262143;
    r.t = t[15:0];
    r.p = p[17:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      osr <= '0; cal_a <= '0; cal_b <= '0; cal_c <= '0;
      fail_count = 0;
      readings_due.delete();
    end else begin
      if (in_valid && in_ready) readings_due.push_back(compensate(raw_temperature, raw_pressure));
      if (out_valid && out_ready) begin
        if (readings_due.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = readings_due.pop_front();
          if (temperature_tenths !== want.t)
            report_mismatch("temperature", temperature_tenths, want.t);
          if (pressure_pascal !== want.p) report_mismatch("pressure", pressure_pascal, want.p);
          if (divide_fault !== want.fault) report_mismatch("fault", divide_fault, want.fault);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_OVERSAMPLING: osr <= cfg_data[1:0];
          REG_CAL_A:        cal_a <= cfg_data;
          REG_CAL_B:        cal_b <= cfg_data;
          REG_CAL_C:        cal_c <= cfg_data[31:0];
          default:          ;
        endcase
      end
    end
    pending = readings_due.size();
  end
endmodule

/* sim/tb.sv */
// testbench top for the barometric sensor compensation pipeline: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb;
  import bsc_pkg::*;

  localparam int LATENCY = 71;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        raw_temperature = '0;
  logic [23:0]        raw_pressure = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] temperature_tenths;
  logic [17:0]        pressure_pascal;
  logic               divide_fault;
  int                 fail_count, pending;
  int                 send_idle_pct = 0, stall_pct = 0, hold_off = 0;
  int                 cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  barometric_sensor_compensation DUT (.*);

  bsc_checker u_checker (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  // request: raise valid, hold until taken; valid stays up for a following request
  task automatic send(logic [15:0] ut, logic [23:0] up);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; raw_temperature <= ut; raw_pressure <= up;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // typical calibration with small random spread
  task automatic set_cal(logic [1:0] os);
    write_reg(REG_OVERSAMPLING, 64'(os));
    write_reg(REG_CAL_A, {16'(408 + $urandom_range(200)), 16'(-72 - $urandom_range(50)),
                          16'(-14383 + $urandom_range(300)), 16'(32741 + $urandom_range(500))});
    write_reg(REG_CAL_B, {16'(32757 - $urandom_range(500)), 16'(23153 + $urandom_range(500)),
                          16'(6190 + $urandom_range(100)), 16'(4 + $urandom_range(3))});
    write_reg(REG_CAL_C, {16'(-8711 + $urandom_range(100)), 16'(2868 + $urandom_range(100))});
  endtask

  task automatic random_requests(int n, bit typical);
    repeat (n) begin
      if (typical) send(16'(25000 + $urandom_range(12000)), 24'($urandom_range(24'hffffff)));
      else send(16'($urandom), 24'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    // reset calibration: temperature divisor is zero
    send(16'd0, 24'd0);
    send(16'hffff, 24'hffffff);
    drain();
    set_cal(2'd0);
    send(16'd27898, 24'h5d2380);
    send(16'd0, 24'd0);
    send(16'hffff, 24'hffffff);
    send(16'hffff, 24'd0);
    send(16'd0, 24'hffffff);
    drain();
    // zero temperature divisor: ac5 = 1, ac6 = ut, md = 0
    write_reg(REG_CAL_B, {16'd1, 16'd1000, 16'd6190, 16'd4});
    write_reg(REG_CAL_C, {16'd100, 16'd0});
    send(16'd1000, 24'h123456);
    drain();
    // zero pressure divisor: ac4 = 0
    write_reg(REG_CAL_A, {16'd408, -16'sd72, -16'sd14383, 16'd0});
    write_reg(REG_CAL_B, {16'd32757, 16'd23153, 16'd6190, 16'd4});
    write_reg(REG_CAL_C, {-16'sd8711, 16'd2868});
    send(16'd27898, 24'h5d2380);
    drain();
    // extreme calibration words
    write_reg(REG_OVERSAMPLING, 64'd3);
    write_reg(REG_CAL_A, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_CAL_B, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_CAL_C, 64'h0000_0000_ffff_ffff);
    send(16'd0, 24'd0); send(16'hffff, 24'hffffff); send(16'h8000, 24'h800000);
    drain();
    write_reg(REG_CAL_A, 64'h7fff_8000_7fff_ffff);
    write_reg(REG_CAL_B, 64'hffff_0000_8000_7fff);
    write_reg(REG_CAL_C, 64'h0000_0000_8000_7fff);
    send(16'd0, 24'd0); send(16'hffff, 24'hffffff); send(16'h1234, 24'h0f0f0f);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      set_cal(2'(phase));
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      if (phase == 2) hold_off = 300;
      random_requests(80, 1'b1);
      random_requests(20, 1'b0);
      // sender waits for every outstanding result
      drain();
    end
    // random calibration words
    for (int k = 0; k < 2; k++) begin
      write_reg(REG_OVERSAMPLING, 64'($urandom_range(3)));
      write_reg(REG_CAL_A, {$urandom, $urandom});
      write_reg(REG_CAL_B, {$urandom, $urandom});
      write_reg(REG_CAL_C, 64'($urandom));
      random_requests(25, 1'b0);
      drain();
    end

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
